// ===== design/dlbh_pkg.sv =====
package dlbh_pkg;

	localparam logic [63:0] LANE_A_INIT = 64'd14695981039346656037;
	localparam logic [63:0] LANE_B_INIT = 64'd13166748625691186689;
	localparam logic [63:0] FNV_PRIME_64 = 64'd1099511628211;
	localparam logic [63:0] GOLDEN_MULT = 64'd11400714819323198485;
	localparam logic [63:0] LENGTH_MULT = 64'h9e3779b97f4a7c15;

	typedef struct packed {
		logic [63:0] lane_a;
		logic [63:0] lane_b;
		logic [63:0] byte_count;
		logic [63:0] len_mult;
	} lane_state_t;

	typedef struct packed {
		logic [63:0] digest_first;
		logic [63:0] digest_second;
	} digest_t;

	localparam lane_state_t STATE_INIT = '{
		lane_a:     LANE_A_INIT,
		lane_b:     LANE_B_INIT,
		byte_count: 64'd0,
		len_mult:   64'd0
	};

endpackage

// ===== design/dlbh_in_if.sv =====
interface dlbh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output has_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input last_byte,
		output ready);
endinterface

// ===== design/dlbh_out_if.sv =====
interface dlbh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_first;
	logic [63:0] digest_second;

	modport source (output valid, output digest_first, output digest_second, input ready);
	modport sink (input valid, input digest_first, input digest_second, output ready);
endinterface

// ===== design/dlbh_step.sv =====
module dlbh_step import dlbh_pkg::*; (
	input  lane_state_t cur,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output lane_state_t nxt,
	output digest_t     dig
);

	logic [63:0] mix_a;
	logic [63:0] mix_b;
	logic [63:0] byte_pos;
	logic [5:0]  shift;
	lane_state_t absorbed;

	// Low 64 bits of x * k from three 32 x 32 partial products. The high x high
	// product only reaches bit 64 and above, and of the cross products only the low
	// halves land below bit 64, so their sum may wrap at 32 bits.
	function automatic logic [63:0] mul_lo64(input logic [63:0] x, input logic [63:0] k);
		logic [63:0] p_ll;
		logic [31:0] p_lh;
		logic [31:0] p_hl;
		p_ll = {32'd0, x[31:0]} * {32'd0, k[31:0]};
		p_lh = x[31:0] * k[63:32];
		p_hl = x[63:32] * k[31:0];
		return p_ll + {p_lh + p_hl, 32'd0};
	endfunction

	// Lane B places the byte at byte position (count mod 8) before mixing.
	assign shift = {cur.byte_count[2:0], 3'b000};
	assign byte_pos = {56'd0, data_byte} << shift;
	assign mix_a = cur.lane_a ^ {56'd0, data_byte};
	assign mix_b = cur.lane_b ^ byte_pos;

	// Both products are constant multiplies truncated to 64 bits. The length term
	// count * LENGTH_MULT is kept as a running sum so no second multiply is needed.
	always_comb begin
		absorbed = cur;
		if (has_byte) begin
			absorbed.lane_a = mul_lo64(mix_a, FNV_PRIME_64);
			absorbed.lane_b = mul_lo64(mix_b, GOLDEN_MULT);
			absorbed.byte_count = cur.byte_count + 64'd1;
			absorbed.len_mult = cur.len_mult + LENGTH_MULT;
		end
	end

	assign dig.digest_first = absorbed.lane_a ^ absorbed.byte_count;
	assign dig.digest_second = absorbed.lane_b ^ absorbed.len_mult;
	assign nxt = last_byte ? STATE_INIT : absorbed;

endmodule

// ===== design/dual_lane_byte_hash.sv =====
// Two-lane 64-bit byte-stream hash (FNV-1a 64 plus a positional multiplicative lane).
// One message byte is taken per msg transfer; a new transfer is accepted every cycle
// while msg.ready is high. An item with has_byte low adds nothing, so last_byte with
// has_byte low closes a message, including an empty one. The item carrying last_byte
// produces one digest transfer, after which both lanes and the count are back at
// their initial values for the next message. Throughput is one item per cycle unless
// stalled, set by the single stage that feeds each lane through its 64-bit constant
// multiply and back into the lane register. msg.ready drops only while a finished
// digest waits on digest.ready and the registered item is another message end.
module dual_lane_byte_hash import dlbh_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	dlbh_in_if.sink     msg,
	dlbh_out_if.source  digest
);

	logic        v_s1;
	logic [7:0]  data_s1;
	logic        has_s1;
	logic        last_s1;
	lane_state_t state_q;
	lane_state_t state_next;
	digest_t     dig_comb;
	digest_t     digest_q;
	logic        res_valid_q;
	logic        stall;
	logic        fire;

	assign stall = v_s1 && last_s1 && res_valid_q && !digest.ready;
	assign fire = v_s1 && !stall;
	assign msg.ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (msg.ready) begin
			v_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_s1 <= msg.data_byte;
			has_s1 <= msg.has_byte;
			last_s1 <= msg.last_byte;
		end
	end

	dlbh_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.has_byte  (has_s1),
		.last_byte (last_s1),
		.nxt       (state_next),
		.dig       (dig_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_INIT;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (digest.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			digest_q <= dig_comb;
		end
	end

	assign digest.valid = res_valid_q;
	assign digest.digest_first = digest_q.digest_first;
	assign digest.digest_second = digest_q.digest_second;

endmodule

// ===== design/dlbh_check.sv =====
module dlbh_check (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_last_byte,
	input logic        digest_valid,
	input logic        digest_ready,
	input logic [63:0] digest_first,
	input logic [63:0] digest_second
);

	// A waiting digest keeps its value until it is taken.
	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest_first)
			&& $stable(digest_second))
		else $error("digest changed while stalled");

	// A fresh digest follows an accepted message end.
	a_digest_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> $past(msg_valid && msg_ready && msg_last_byte, 2))
		else $error("digest without a message end");

	// Input backpressure only comes from a held digest.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!digest_valid |-> msg_ready)
		else $error("input stalled with empty output");

	// The input is blocked only while a digest is held and not taken.
	a_ready_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_ready |-> digest_valid && !digest_ready)
		else $error("input stalled without output backpressure");

endmodule

bind dual_lane_byte_hash dlbh_check u_dlbh_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.msg_valid     (msg.valid),
	.msg_ready     (msg.ready),
	.msg_last_byte (msg.last_byte),
	.digest_valid  (digest.valid),
	.digest_ready  (digest.ready),
	.digest_first  (digest.digest_first),
	.digest_second (digest.digest_second)
);
